// ===== design/ese_pkg.sv =====
// Shared constants and types of the exchange sort engine.
`timescale 1ns / 1ps

package ese_pkg;

  // Element width and default chain length
  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic insert;  // place the incoming word in order
    logic shift;   // move every cell one place towards the head
  } cell_ctrl_t;

endpackage

// ===== design/ese_cell.sv =====
// One cell of the sorting chain: holds a single element and its occupancy bit.
`timescale 1ns / 1ps

module ese_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ese_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [ese_pkg::VALUE_W-1:0]  new_value,
  input  logic signed [ese_pkg::VALUE_W-1:0]  left_value,
  input  logic                                left_valid,
  input  logic                                left_take,
  input  logic signed [ese_pkg::VALUE_W-1:0]  right_value,
  input  logic                                right_valid,
  output logic signed [ese_pkg::VALUE_W-1:0]  value,
  output logic                                valid,
  output logic                                take
);
  import ese_pkg::*;

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      valid_r, valid_nxt;

  // An empty cell or one holding a larger element gives way to the new word
  assign take = !valid_r || (new_value < value_r);

  // Insert: take the left neighbour's element if it also gives way, else the new word.
  // Shift: take the right neighbour's element.
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctrl.insert && take) begin
      if (left_take) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// ===== design/exchange_sort_engine.sv =====
// Top level of the exchange sort engine: load/drain control around a chain of sorting cells.
// Load: one input word per cycle; each kept word is placed in order in the same cycle it is accepted.
// Drain: starts the cycle after the closing word; the smallest element is shown at once
//   and one result per cycle follows while out_stall is low, until all N kept words are out.
// Input is stalled while a set drains; the order is set by the combinational insert compare.
// Reset (synchronous, active low) empties all cells and clears the count and overflow flag.
`timescale 1ns / 1ps

module exchange_sort_engine #(
  parameter int MAX_ITEMS = ese_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ese_pkg::VALUE_W-1:0]  in_value,
  input  logic                                in_last_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ese_pkg::VALUE_W-1:0]  out_sorted_value,
  output logic                                out_last_result,
  output logic                                out_overflow
);
  import ese_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  localparam logic PH_LOAD  = 1'b0;
  localparam logic PH_DRAIN = 1'b1;

  logic              phase_r, phase_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r,  drop_nxt;

  logic              in_acc, out_acc, room;
  cell_ctrl_t        ctrl;

  logic signed [VALUE_W-1:0] cell_val  [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]      cell_vld;
  logic [MAX_ITEMS-1:0]      cell_take;

  // Handshakes
  assign in_stall  = (phase_r == PH_DRAIN);
  assign out_valid = (phase_r == PH_DRAIN);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign room      = (count_r < CNT_W'(MAX_ITEMS));

  assign ctrl.insert = in_acc && room;
  assign ctrl.shift  = out_acc;

  // Sequence load and drain phases
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    unique case (phase_r)
      PH_LOAD: begin
        if (in_acc) begin
          if (room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_item) begin
            phase_nxt = PH_DRAIN;
          end
        end
      end
      PH_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            phase_nxt = PH_LOAD;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: begin
        phase_nxt = PH_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Build the cell chain; the head holds the smallest element
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv, rv;
    logic                      lvd, ltk, rvd;

    if (i == 0) begin : g_head
      assign lv  = '0;
      assign lvd = 1'b0;
      assign ltk = 1'b0;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign lvd = cell_vld[i-1];
      assign ltk = cell_take[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign rv  = '0;
      assign rvd = 1'b0;
    end else begin : g_body
      assign rv  = cell_val[i+1];
      assign rvd = cell_vld[i+1];
    end

    ese_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_value   (in_value),
      .left_value  (lv),
      .left_valid  (lvd),
      .left_take   (ltk),
      .right_value (rv),
      .right_valid (rvd),
      .value       (cell_val[i]),
      .valid       (cell_vld[i]),
      .take        (cell_take[i])
    );
  end

  // Present the head cell as the result word
  assign out_sorted_value = cell_val[0];
  assign out_last_result  = (count_r == CNT_W'(1));
  assign out_overflow     = drop_r;

  // Occupied cells always match the element count
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == int'(count_r))
    else $error("cell occupancy disagrees with element count");

  // A draining set is never empty
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DRAIN) |-> (count_r != '0))
    else $error("drain phase with no elements");

  // Head and its neighbour stay in ascending order
  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    cell_vld[1] |-> (cell_val[0] <= cell_val[1]))
    else $error("head cells out of order");

  // Taking the final result returns to load with the flag cleared
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_result) |=> (phase_r == PH_LOAD && count_r == '0 && !drop_r))
    else $error("set did not close cleanly");

endmodule
